@@ rtl/olit_pkg.sv @@
// ----------------------------------------------------------------------------
// olit_pkg
// Shared types and constants for the ordered list insert/traverse unit:
// word layouts, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package olit_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_WIDTH  = 32;
  localparam int CMD_W        = 2;
  localparam int POS_W        = 6;
  localparam int STAT_W       = 3;
  localparam int LEN_W        = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_READ_FWD = 2'd1,
    CMD_READ_REV = 2'd2
  } olit_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_BAD_POS  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_ELEMENT  = 3'd3,
    STAT_EMPTY    = 3'd4
  } olit_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]              command;
    logic [POS_W-1:0]              position;
    logic signed [VALUE_WIDTH-1:0] value;
  } olit_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]             status;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic                          is_last;
    logic [LEN_W-1:0]              list_length;
  } olit_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_LINK_A,
    ST_LINK_B,
    ST_RESP,
    ST_STREAM
  } olit_state_t;

  typedef struct packed {
    logic         latch;
    logic         start_walk;
    logic         step;
    logic         link_a;
    logic         link_b;
    logic         start_read;
    logic         emit_elem;
    logic         emit_status;
    olit_status_t code;
  } olit_dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_read;
    logic bad_pos;
    logic full;
    logic empty;
    logic steps_zero;
    logic last_elem;
    logic out_free;
  } olit_dp_stat_t;

endpackage

@@ rtl/olit_ram.sv @@
// ----------------------------------------------------------------------------
// olit_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module olit_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/olit_ctrl.sv @@
// ----------------------------------------------------------------------------
// olit_ctrl
// Controller state machine: accepts a word, checks it, sequences the link
// walk and splice of an insert, and paces the stream of a read.
// ----------------------------------------------------------------------------
module olit_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  olit_pkg::olit_dp_stat_t stat_i,
  output olit_pkg::olit_dp_cmd_t  cmd_o
);
  import olit_pkg::*;

  olit_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    cmd_o.code = STAT_INSERTED;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.is_insert) begin
          if (stat_i.bad_pos || stat_i.full) begin
            cmd_o.code = stat_i.bad_pos ? STAT_BAD_POS : STAT_FULL;
            if (stat_i.out_free) begin
              cmd_o.emit_status = 1'b1;
              state_nxt         = ST_IDLE;
            end
          end else begin
            cmd_o.start_walk = 1'b1;
            state_nxt        = ST_WALK;
          end
        end else if (stat_i.is_read) begin
          if (stat_i.empty) begin
            cmd_o.code = STAT_EMPTY;
            if (stat_i.out_free) begin
              cmd_o.emit_status = 1'b1;
              state_nxt         = ST_IDLE;
            end
          end else begin
            cmd_o.start_read = 1'b1;
            state_nxt        = ST_STREAM;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (stat_i.steps_zero) begin
          state_nxt = ST_LINK_A;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_LINK_A: begin
        cmd_o.link_a = 1'b1;
        state_nxt    = ST_LINK_B;
      end
      ST_LINK_B: begin
        cmd_o.link_b = 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.code = STAT_INSERTED;
        if (stat_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (stat_i.out_free) begin
          cmd_o.emit_elem = 1'b1;
          if (stat_i.last_elem) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/olit_dp.sv @@
// ----------------------------------------------------------------------------
// olit_dp
// Datapath: request register, entry count, sentinel links, value and link
// memories, traversal pointer and the output word register.
// ----------------------------------------------------------------------------
module olit_dp #(
  parameter int CAPACITY = olit_pkg::CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  olit_pkg::olit_in_t      in_data,
  input  olit_pkg::olit_dp_cmd_t  cmd_i,
  output olit_pkg::olit_dp_stat_t stat_o,
  output olit_pkg::olit_out_t     out_data,
  output logic                    out_valid,
  input  logic                    out_ready
);
  import olit_pkg::*;

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] SENT = LW'(CAPACITY);

  olit_in_t         req_r;
  logic [LW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    ptr_r, ptr_nxt;
  logic [LW-1:0]    head_next_r, head_prev_r;
  logic [LW-1:0]    nxt_r;
  logic [POS_W-1:0] steps_r;
  logic [LW-1:0]    elem_cnt_r;
  olit_out_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic                   succ_we, pred_we, val_we;
  logic [IW-1:0]          succ_waddr, pred_waddr, slot_new, rd_addr;
  logic [LW-1:0]          succ_wdata, pred_wdata, succ_q, pred_q;
  logic [VALUE_WIDTH-1:0] val_q;

  logic          rev, out_free, load_out;
  logic [LW-1:0] link_fwd, link_rev;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic [LW:0]   elem_plus;

  assign rev      = (req_r.command == CMD_READ_REV);
  assign link_fwd = (ptr_r == SENT) ? head_next_r : succ_q;
  assign link_rev = (ptr_r == SENT) ? head_prev_r : pred_q;
  assign slot_new = count_r[IW-1:0];
  assign pos_ext  = CMPW'(req_r.position);
  assign cnt_ext  = CMPW'(count_r);
  assign elem_plus = (LW+1)'(elem_cnt_r) + (LW+1)'(1);
  assign out_free = !out_valid_r || out_ready;
  assign load_out = cmd_i.emit_elem || cmd_i.emit_status;

  always_comb begin
    stat_o.is_insert  = (req_r.command == CMD_INSERT);
    stat_o.is_read    = (req_r.command == CMD_READ_FWD) || rev;
    stat_o.bad_pos    = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
    stat_o.full       = (count_r == SENT);
    stat_o.empty      = (count_r == '0);
    stat_o.steps_zero = (steps_r == '0);
    stat_o.last_elem  = (elem_plus == (LW+1)'(count_r));
    stat_o.out_free   = out_free;
  end

  // traversal pointer, shared by the insert walk and the read stream
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd_i.start_walk) begin
      ptr_nxt = SENT;
    end else if (cmd_i.step) begin
      ptr_nxt = link_fwd;
    end else if (cmd_i.start_read) begin
      ptr_nxt = rev ? head_prev_r : head_next_r;
    end else if (cmd_i.emit_elem) begin
      ptr_nxt = rev ? link_rev : link_fwd;
    end
  end

  assign rd_addr = ptr_nxt[IW-1:0];

  // splice: link_a writes the new slot, then link_b patches its neighbors
  always_comb begin
    succ_we    = 1'b0;
    pred_we    = 1'b0;
    val_we     = cmd_i.link_a;
    succ_waddr = slot_new;
    pred_waddr = slot_new;
    succ_wdata = link_fwd;
    pred_wdata = ptr_r;
    if (cmd_i.link_a) begin
      succ_we = 1'b1;
      pred_we = 1'b1;
    end else if (cmd_i.link_b) begin
      succ_we    = (ptr_r != SENT);
      pred_we    = (nxt_r != SENT);
      succ_waddr = ptr_r[IW-1:0];
      pred_waddr = nxt_r[IW-1:0];
      succ_wdata = count_r;
      pred_wdata = count_r;
    end
  end

  assign count_nxt = cmd_i.link_b ? count_r + LW'(1) : count_r;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_out) begin
      out_valid_nxt         = 1'b1;
      out_nxt.status        = cmd_i.emit_elem ? STAT_ELEMENT : cmd_i.code;
      out_nxt.item_value    = cmd_i.emit_elem ? val_q : '0;
      out_nxt.is_last       = cmd_i.emit_elem ? stat_o.last_elem : 1'b1;
      out_nxt.list_length   = cnt_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_next_r <= SENT;
      head_prev_r <= SENT;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd_i.link_b && ptr_r == SENT) begin
        head_next_r <= count_r;
      end
      if (cmd_i.link_b && nxt_r == SENT) begin
        head_prev_r <= count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    out_r <= out_nxt;
    if (cmd_i.latch) begin
      req_r <= in_data;
    end
    if (cmd_i.start_walk) begin
      steps_r <= req_r.position - POS_W'(1);
    end else if (cmd_i.step) begin
      steps_r <= steps_r - POS_W'(1);
    end
    if (cmd_i.start_read) begin
      elem_cnt_r <= '0;
    end else if (cmd_i.emit_elem) begin
      elem_cnt_r <= elem_plus[LW-1:0];
    end
    if (cmd_i.link_a) begin
      nxt_r <= link_fwd;
    end
  end

  olit_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_succ_ram (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .raddr (rd_addr),
    .rdata (succ_q)
  );

  olit_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .raddr (rd_addr),
    .rdata (pred_q)
  );

  olit_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_new),
    .wdata (req_r.value),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SENT)
    else $error("entry count above capacity");

  a_count_only_on_splice: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(cmd_i.link_b))
    else $error("entry count changed outside a splice");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("output word overwritten before taken");

  a_splice_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.link_a |-> (count_r < SENT))
    else $error("splice into a full list");

  a_stream_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit_elem |-> (req_r.command == CMD_READ_FWD || req_r.command == CMD_READ_REV))
    else $error("element streamed for a non-read word");

endmodule

@@ rtl/ordered_list_insert_traverse_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_traverse_unit
// Bounded ordered list of signed values kept as a circular doubly linked
// list, with insert-before-position, forward read and reverse read.
// ----------------------------------------------------------------------------
// One word is handled at a time. An insert at position p walks the
// successor links one hop per cycle through the registered-read link
// memory, then splices the new slot in: link A writes the slot, link B
// patches its neighbors. A read of n entries streams one result per cycle
// while the output register is free. A rejected insert or an empty read
// answers with one status word; an unused command gives no result. A new
// word is taken as soon as the previous one has produced its last result,
// even while that result still waits in the output register. No clearing
// pass is needed after reset.
module ordered_list_insert_traverse_unit #(
  parameter int CAPACITY = olit_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  olit_pkg::olit_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output olit_pkg::olit_out_t out_data
);
  import olit_pkg::*;

  olit_dp_cmd_t  dp_cmd;
  olit_dp_stat_t dp_stat;

  olit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  olit_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
